>>> rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  // Field and register widths
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 17;
  localparam int COUNT_W       = 7;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;

  // Default number of slots in the used-slot bitmap
  localparam int DEF_MAX_SLOTS = 64;

  // Bitmap scan: lanes examined per cycle
  localparam int SCAN_LANES    = 8;
  localparam int LANE_W        = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = 1;
  localparam int QUEUE_CNT_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  // Classified request: kind plus the offset of the address from the pool base
  typedef struct packed {
    req_kind_t           kind;
    logic [ADDR_W-1:0]   offset;
  } item_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/fbpa_front.sv
// Front stage: accept requests, classify them and compute the pool offset.
module fbpa_front import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ADDR_W-1:0] in_tdata,   // [31:0] free_address
  input  logic              in_tuser,   // [0] req_type
  input  logic [ADDR_W-1:0] pool_base,
  output logic              item_valid,
  output item_t             item,
  input  logic              item_ready
);

  logic  stage_v_r, stage_v_nxt;
  item_t stage_item_r, stage_item_nxt;
  logic  accept;

  assign in_tready  = !stage_v_r || item_ready;
  assign accept     = in_tvalid && in_tready;
  assign item_valid = stage_v_r;
  assign item       = stage_item_r;

  always_comb begin
    stage_v_nxt    = stage_v_r && !item_ready;
    stage_item_nxt = stage_item_r;
    if (accept) begin
      stage_v_nxt           = 1'b1;
      stage_item_nxt.kind   = req_kind_t'(in_tuser);
      // wraps modulo 2^32, matching the wrapped addresses handed out
      stage_item_nxt.offset = in_tdata - pool_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_item_r <= stage_item_nxt;
  end

endmodule

>>> rtl/fbpa_queue.sv
// Short request queue between the front and back stages.
module fbpa_queue import fbpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  item_t   push_item,
  output logic    push_ready,
  output logic    pop_valid,
  output item_t   pop_item,
  input  logic    pop_ready,
  output q_stat_t stat
);

  item_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   push, pop;

  assign stat.full  = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_item   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/fbpa_back.sv
// Back stage: bitmap scan for allocate, range check and divide for free.
module fbpa_back import fbpa_pkg::*; #(
  parameter  int MAX_SLOTS = DEF_MAX_SLOTS,
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1),
  localparam int SPAN_W    = SIZE_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  item_t             item,
  output logic              item_ready,
  input  logic [ADDR_W-1:0] pool_base,
  input  logic [SIZE_W-1:0] eff_size,
  input  logic [CNT_W-1:0]  eff_count,
  input  logic [SPAN_W-1:0] span,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ADDR_W-1:0] out_tdata,
  output logic [1:0]        out_tuser
);

  localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CHUNK_N = (MAX_SLOTS + SCAN_LANES - 1) / SCAN_LANES;
  localparam int CHUNK_W = (CHUNK_N > 1) ? $clog2(CHUNK_N) : 1;
  localparam int PAD_N   = CHUNK_N * SCAN_LANES;
  localparam int PROD_W  = SLOT_W + SIZE_W;
  localparam int STEP_W  = $clog2(SLOT_W + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ADD   = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MAX_SLOTS-1:0] used_r, used_nxt;
  logic [CHUNK_W-1:0]  chunk_r, chunk_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ADDR_W-1:0]   offset_r, offset_nxt;
  logic [SPAN_W-1:0]   rem_r, rem_nxt;
  logic [SPAN_W-1:0]   dv_r, dv_nxt;
  logic [SLOT_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             res_st_r, res_st_nxt;
  logic                out_v_r, out_v_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_st_r, out_st_nxt;

  logic [PAD_N-1:0]      used_pad;
  logic [SCAN_LANES-1:0] window;
  logic                  hit;
  logic [LANE_W-1:0]     hit_pos;
  logic [SLOT_W-1:0]     hit_slot;
  logic                  div_ge;
  logic [SLOT_W-1:0]     div_q;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_st_r;

  // Lowest free slot in the current chunk of eight, limited to the active count
  always_comb begin
    used_pad                 = '1;
    used_pad[MAX_SLOTS-1:0]  = used_r;
    window                   = used_pad[chunk_r*SCAN_LANES +: SCAN_LANES];
    hit                      = 1'b0;
    hit_pos                  = '0;
    for (int j = SCAN_LANES - 1; j >= 0; j--) begin
      if (!window[j] && ((int'(chunk_r) * SCAN_LANES + j) < int'(eff_count))) begin
        hit     = 1'b1;
        hit_pos = LANE_W'(j);
      end
    end
    hit_slot = SLOT_W'(int'(chunk_r) * SCAN_LANES + int'(hit_pos));
  end

  // One restoring divide step per cycle
  assign div_ge = (rem_r >= dv_r);
  assign div_q  = SLOT_W'({q_r, div_ge});

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    chunk_nxt    = chunk_r;
    slot_nxt     = slot_r;
    prod_nxt     = prod_r;
    offset_nxt   = offset_r;
    rem_nxt      = rem_r;
    dv_nxt       = dv_r;
    q_nxt        = q_r;
    step_nxt     = step_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_addr_nxt = out_addr_r;
    out_st_nxt   = out_st_r;
    item_ready   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          offset_nxt = item.offset;
          chunk_nxt  = '0;
          state_nxt  = (item.kind == REQ_FREE) ? S_CHECK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          slot_nxt           = hit_slot;
          used_nxt[hit_slot] = 1'b1;
          state_nxt          = S_MUL;
        end else if (chunk_r == CHUNK_W'(CHUNK_N - 1)) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_FULL;
          state_nxt    = S_DONE;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(slot_r) * PROD_W'(eff_size);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        res_addr_nxt = pool_base + ADDR_W'(prod_r);
        res_st_nxt   = ST_OK;
        state_nxt    = S_DONE;
      end
      S_CHECK: begin
        if (offset_r >= ADDR_W'(span)) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_BAD_FREE;
          state_nxt    = S_DONE;
        end else begin
          rem_nxt   = SPAN_W'(offset_r);
          dv_nxt    = SPAN_W'(eff_size) << (SLOT_W - 1);
          q_nxt     = '0;
          step_nxt  = STEP_W'(SLOT_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? rem_r - dv_r : rem_r;
        dv_nxt  = dv_r >> 1;
        q_nxt   = div_q;
        if (step_r == '0) begin
          used_nxt[div_q] = 1'b0;
          res_addr_nxt    = '0;
          res_st_nxt      = ST_OK;
          state_nxt       = S_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt    = 1'b1;
          out_addr_nxt = res_addr_r;
          out_st_nxt   = res_st_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chunk_r    <= chunk_nxt;
    slot_r     <= slot_nxt;
    prod_r     <= prod_nxt;
    offset_r   <= offset_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

endmodule

>>> rtl/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator: config registers, front, queue, back.
//
// Usage: each in_ transaction is one request. in_tuser is the request kind
// (0 allocate, 1 free) and in_tdata the address to free. Each request yields
// exactly one out_ transaction: out_tdata is the allocated block address
// (zero on pool full and on every free), out_tuser the status (0 ok,
// 1 pool full, 2 free address out of range).
// Write cfg_ registers (0 pool base, 1 block size, 2 block count) only while
// the block is idle; a write takes effect at the clock edge with cfg_we high.
// Timing: a front register, a two-entry queue and the back unit sit in line.
// The back unit serves one request at a time and sets the rate. An allocate
// steps through SCAN, one eight-slot chunk per cycle until a free slot is
// found, then MUL, ADD and DONE; a pool-full allocate scans every chunk and
// goes to DONE. A free steps through CHECK, then DIV, one quotient bit per
// cycle, then DONE; an out-of-range free goes from CHECK straight to DONE.
// Reset clears the bitmap (all slots free), the queue and the output register,
// and loads base 0, size 1, count 64. When out_tready is low the result holds
// in the output register; the front and queue keep taking requests until they fill.
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ADDR_W-1:0]    in_tdata,   // [31:0] free_address
  input  logic                 in_tuser,   // [0] req_type
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ADDR_W-1:0]    out_tdata,  // [31:0] block_address
  output logic [1:0]           out_tuser,  // [1:0] status
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SPAN_W = SIZE_W + CNT_W;

  logic [ADDR_W-1:0]  pool_base_r, pool_base_nxt;
  logic [SIZE_W-1:0]  block_size_r, block_size_nxt;
  logic [COUNT_W-1:0] block_count_r, block_count_nxt;
  logic [SPAN_W-1:0]  span_r;
  logic [SIZE_W-1:0]  eff_size;
  logic [CNT_W-1:0]   eff_count;

  logic    fr_valid, fr_ready;
  item_t   fr_item;
  logic    bk_valid, bk_ready;
  item_t   bk_item;
  q_stat_t q_stat;

  // Configuration decode; unknown indexes drop the write
  always_comb begin
    pool_base_nxt   = pool_base_r;
    block_size_nxt  = block_size_r;
    block_count_nxt = block_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:   pool_base_nxt   = cfg_wdata[ADDR_W-1:0];
        CFG_BLOCK_SIZE:  block_size_nxt  = cfg_wdata[SIZE_W-1:0];
        CFG_BLOCK_COUNT: block_count_nxt = cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      block_size_r  <= SIZE_W'(1);
      block_count_r <= COUNT_W'(DEF_MAX_SLOTS);
    end else begin
      pool_base_r   <= pool_base_nxt;
      block_size_r  <= block_size_nxt;
      block_count_r <= block_count_nxt;
    end
  end

  // Treat a zero size as one byte; clamp the count to the bitmap depth
  assign eff_size  = (block_size_r == '0) ? SIZE_W'(1) : block_size_r;
  assign eff_count = (int'(block_count_r) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
                                                       : CNT_W'(block_count_r);

  // Pool span in bytes, registered off the config path
  always_ff @(posedge clk) begin
    span_r <= SPAN_W'(eff_size) * SPAN_W'(eff_count);
  end

  fbpa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .pool_base  (pool_base_r),
    .item_valid (fr_valid),
    .item       (fr_item),
    .item_ready (fr_ready)
  );

  fbpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_item  (fr_item),
    .push_ready (fr_ready),
    .pop_valid  (bk_valid),
    .pop_item   (bk_item),
    .pop_ready  (bk_ready),
    .stat       (q_stat)
  );

  fbpa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (bk_valid),
    .item       (bk_item),
    .item_ready (bk_ready),
    .pool_base  (pool_base_r),
    .eff_size   (eff_size),
    .eff_count  (eff_count),
    .span       (span_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Only a successful request may carry a nonzero address
  a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("nonzero address on a failed request");

  // The queue cannot be full and empty at once
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue flags inconsistent");

  // A front item blocked by a full queue holds until it is taken
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid && !fr_ready |=> fr_valid && $stable(fr_item))
    else $error("front item lost while queue full");

endmodule
